// ===== rtl/stpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, phase codes and controller/datapath structs of the stepper ramp.
package stpr_pkg;

  localparam int unsigned MIN_RATE   = 100;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned SPEED_BITS = 16;
  localparam int unsigned CONT_RATE  = 100;

  localparam int unsigned SPD_W  = SPEED_BITS + 2;
  localparam int unsigned STP_W  = COUNT_BITS + 1;
  localparam int unsigned DP_W   = COUNT_BITS - 1;
  localparam int unsigned RATE_W = SPEED_BITS + 1;
  localparam int unsigned RES_W  = 3;
  localparam int unsigned PH_W   = 2;

  localparam int unsigned RECIP_SHIFT = COUNT_BITS + 3;
  localparam int unsigned RECIP_W     = RECIP_SHIFT - 2;
  localparam longint unsigned RECIP_VAL = ((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];

  localparam int unsigned DIV_CNT_W = $clog2(SPEED_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SPEED_BITS - 1);

  localparam logic [RES_W-1:0] RES_MAX = 3'd5;

  localparam logic [PH_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PH_W-1:0] PH_ACC   = 2'd1;
  localparam logic [PH_W-1:0] PH_CONST = 2'd2;
  localparam logic [PH_W-1:0] PH_DEC   = 2'd3;

  typedef struct packed {
    logic load;
    logic start;
    logic tick;
    logic div_step;
    logic finish;
    logic wb;
  } stpr_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_cont;
  } stpr_stat_t;

endpackage

// ===== rtl/stpr_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: start and tick items with valid/ready handshake.
interface stpr_in_if import stpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [SPEED_BITS-1:0] target_speed;
  logic [COUNT_BITS-1:0] step_count;
  logic                  continuous;
  logic [RES_W-1:0]      microstep_code;

  modport source (
    output valid, kind, target_speed, step_count, continuous, microstep_code,
    input  ready
  );
  modport sink (
    input  valid, kind, target_speed, step_count, continuous, microstep_code,
    output ready
  );
endinterface

// ===== rtl/stpr_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: pin levels, phase and speed after each item.
interface stpr_out_if import stpr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    step_level;
  logic                    driver_enable_n;
  logic                    busy_led;
  logic                    direction_level;
  logic [PH_W-1:0]         phase;
  logic signed [SPD_W-1:0] current_speed;
  logic [RES_W-1:0]        resolution_code;

  modport source (
    output valid, step_level, driver_enable_n, busy_led, direction_level, phase,
           current_speed, resolution_code,
    input  ready
  );
  modport sink (
    input  valid, step_level, driver_enable_n, busy_led, direction_level, phase,
           current_speed, resolution_code,
    output ready
  );
endinterface

// ===== rtl/stpr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: item sequencing, divider step count, result register valid.
module stpr_ctrl import stpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  stpr_stat_t stat_i,
  output stpr_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_tick) begin
          cmd_o.tick = 1'b1;
          state_d    = S_WB;
        end else begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = stat_i.is_cont ? S_WB : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_WB;
      end
      S_WB: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.wb = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.wb) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/stpr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: ramp state, deceleration point, restoring rate divider and result register.
module stpr_datapath import stpr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  input  stpr_cmd_t               cmd_i,
  output stpr_stat_t              stat_o,
  input  logic                    kind_i,
  input  logic [SPEED_BITS-1:0]   target_speed_i,
  input  logic [COUNT_BITS-1:0]   step_count_i,
  input  logic                    continuous_i,
  input  logic [RES_W-1:0]        microstep_code_i,
  output logic                    step_level_o,
  output logic                    driver_enable_n_o,
  output logic                    busy_led_o,
  output logic                    direction_level_o,
  output logic [PH_W-1:0]         phase_o,
  output logic signed [SPD_W-1:0] current_speed_o,
  output logic [RES_W-1:0]        resolution_code_o
);

  localparam logic [SPD_W-1:0]  MIN_SPD   = SPD_W'(MIN_RATE);
  localparam logic [RATE_W-1:0] MIN_DIFF  = RATE_W'(MIN_RATE);
  localparam logic [RATE_W-1:0] CONT_R    = RATE_W'(CONT_RATE);
  localparam logic [RATE_W-1:0] RATE_MAX  = {1'b0, {SPEED_BITS{1'b1}}};

  // latched item
  logic                  kind_q;
  logic [SPEED_BITS-1:0] tgt_in_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [STP_W-1:0]      cntp_q;
  logic                  cont_q;
  logic [RES_W-1:0]      code_q;

  // ramp state
  logic [PH_W-1:0]       phase_q;
  logic [SPD_W-1:0]      speed_q;
  logic [SPEED_BITS-1:0] target_q;
  logic [STP_W-1:0]      steps_q;
  logic [DP_W-1:0]       dp_q;
  logic [RATE_W-1:0]     rate_q;
  logic                  pulse_q;
  logic [RES_W-1:0]      res_q;
  logic                  endless_q;
  logic                  reverse_q;

  // divider
  logic [DP_W-1:0]       rem_q;
  logic [SPEED_BITS-1:0] quo_q;
  logic                  neg_q;

  logic [STP_W+RECIP_W-1:0] prod;
  logic [DP_W-1:0]          dp_calc;
  logic [RATE_W-1:0]        diff;
  logic [RATE_W-1:0]        diff_neg;
  logic                     diff_is_neg;
  logic [SPEED_BITS-1:0]    mag;
  logic [DP_W:0]            rem_sh;
  logic [DP_W:0]            rem_sub;
  logic                     fits;
  logic [RATE_W-1:0]        rate_fin;
  logic [SPD_W-1:0]         rate_ext;
  logic [SPD_W-1:0]         spd_up;
  logic [SPD_W-1:0]         spd_dn;
  logic [STP_W-1:0]         steps_dec;
  logic                     running;

  assign prod    = cntp_q * RECIP;
  assign dp_calc = prod[RECIP_SHIFT +: DP_W];

  assign diff        = {1'b0, tgt_in_q} - MIN_DIFF;
  assign diff_neg    = MIN_DIFF - {1'b0, tgt_in_q};
  assign diff_is_neg = diff[RATE_W-1];
  assign mag         = diff_is_neg ? diff_neg[SPEED_BITS-1:0] : diff[SPEED_BITS-1:0];

  assign rem_sh  = {rem_q, quo_q[SPEED_BITS-1]};
  assign fits    = (rem_sh >= {1'b0, dp_q});
  assign rem_sub = rem_sh - {1'b0, dp_q};

  always_comb begin
    priority if (dp_q == '0) begin
      rate_fin = RATE_MAX;
    end else if (neg_q) begin
      rate_fin = RATE_W'(0) - {1'b0, quo_q};
    end else begin
      rate_fin = {1'b0, quo_q} + RATE_W'(rem_q != '0);
    end
  end

  assign rate_ext  = {{(SPD_W-RATE_W){rate_q[RATE_W-1]}}, rate_q};
  assign spd_up    = speed_q + rate_ext;
  assign spd_dn    = speed_q - rate_ext;
  assign steps_dec = steps_q - 1'b1;
  assign running   = (phase_q != PH_IDLE);

  assign stat_o.is_tick = kind_q;
  assign stat_o.is_cont = cont_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      speed_q   <= '0;
      target_q  <= '0;
      steps_q   <= '0;
      dp_q      <= '0;
      rate_q    <= '0;
      pulse_q   <= 1'b0;
      res_q     <= '0;
      endless_q <= 1'b0;
      reverse_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reverse_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        if (code_q <= RES_MAX) begin
          res_q <= code_q;
        end
        phase_q  <= PH_ACC;
        speed_q  <= MIN_SPD;
        target_q <= tgt_in_q;
        if (cont_q) begin
          endless_q <= 1'b1;
          steps_q   <= '1;
          dp_q      <= '0;
          rate_q    <= CONT_R;
        end else begin
          endless_q <= 1'b0;
          steps_q   <= {1'b0, cnt_q};
          dp_q      <= dp_calc;
        end
      end
      if (cmd_i.tick && running) begin
        steps_q <= steps_dec;
        pulse_q <= ~pulse_q;
        unique case (phase_q)
          PH_ACC: begin
            speed_q <= spd_up;
            if ($signed(spd_up) >= $signed({2'b00, target_q})) begin
              phase_q <= PH_CONST;
            end
          end
          PH_CONST: begin
            if (!endless_q && (steps_dec == {2'b00, dp_q})) begin
              phase_q <= PH_DEC;
            end
          end
          PH_DEC: begin
            speed_q <= spd_dn;
            if ($signed(spd_dn) <= $signed(MIN_SPD)) begin
              phase_q <= PH_IDLE;
            end
          end
          PH_IDLE: begin
          end
        endcase
      end
      if (cmd_i.finish) begin
        rate_q <= rate_fin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      tgt_in_q <= target_speed_i;
      cnt_q    <= step_count_i;
      cntp_q   <= {1'b0, step_count_i} + STP_W'(4);
      cont_q   <= continuous_i;
      code_q   <= microstep_code_i;
    end
    if (cmd_i.start) begin
      rem_q <= '0;
      quo_q <= mag;
      neg_q <= diff_is_neg;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? rem_sub[DP_W-1:0] : rem_sh[DP_W-1:0];
      quo_q <= {quo_q[SPEED_BITS-2:0], fits};
    end
    if (cmd_i.wb) begin
      step_level_o      <= pulse_q;
      driver_enable_n_o <= ~running;
      busy_led_o        <= running;
      direction_level_o <= ~reverse_q;
      phase_o           <= phase_q;
      current_speed_o   <= $signed(speed_q);
      resolution_code_o <= res_q;
    end
  end

endmodule

// ===== rtl/stepper_trapezoid_ramp_core.sv =====
`timescale 1ns / 1ps
// Top level of the trapezoidal stepper ramp: controller, datapath and checks.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid / ready      kind, target_speed, step_count, continuous, microstep_code
//   out_ch    out  valid / ready      step_level ... resolution_code, one per input item
//   cfg       in   cfg_we_i           cfg_wdata_i (reverse)
//
// A tick item or a continuous start goes from load through execute to write-back; a
// counted start also passes the divide and finish states of the one-bit-per-cycle
// restoring divider that forms the ramp rate. One item is in work at a time; the
// result register lets the next item transfer in while a result still waits on
// out_ch, and that item holds in write-back until the waiting result transfers.
// Reset is asynchronous and clears the ramp state; no clearing pass is needed.
module stepper_trapezoid_ramp_core import stpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  stpr_in_if.sink    in_ch,
  stpr_out_if.source out_ch
);

  stpr_cmd_t  cmd;
  stpr_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  stpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stpr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .kind_i            (in_ch.kind),
    .target_speed_i    (in_ch.target_speed),
    .step_count_i      (in_ch.step_count),
    .continuous_i      (in_ch.continuous),
    .microstep_code_i  (in_ch.microstep_code),
    .step_level_o      (out_ch.step_level),
    .driver_enable_n_o (out_ch.driver_enable_n),
    .busy_led_o        (out_ch.busy_led),
    .direction_level_o (out_ch.direction_level),
    .phase_o           (out_ch.phase),
    .current_speed_o   (out_ch.current_speed),
    .resolution_code_o (out_ch.resolution_code)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input transfer taken while an item is in work");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without a work cycle");

  a_enable_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (((out_ch.phase == PH_IDLE) == out_ch.driver_enable_n) &&
                      (out_ch.busy_led != out_ch.driver_enable_n)))
    else $error("driver enable disagrees with phase");

  a_no_work_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !(cmd.tick || cmd.start || cmd.div_step || cmd.finish || cmd.wb))
    else $error("datapath command issued while idle");

endmodule
